>>> rtl/core/rct_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the route cache table.
// No dependencies; the top level and the checker import this package.
package rct_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned MAC_W    = 48;
  localparam int unsigned IF_W     = 4;
  localparam int unsigned HOP_W    = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned STALE_W  = 16;
  localparam int unsigned PADDR_W  = 2;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [TIME_W-1:0]  MS_PER_SEC      = 32'd1000;
  localparam logic [STALE_W-1:0] STALENESS_RESET = 16'd5;
  localparam logic [TIME_W-1:0]  LIMIT_RESET     = 32'd5000;
  localparam logic [HOP_W-1:0]   HOPS_UNKNOWN    = 8'hFF;

  localparam logic [PADDR_W-1:0] REG_STALENESS = 2'd0;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    STS_HIT        = 3'd0,
    STS_UNRESOLVED = 3'd1,
    STS_STALE      = 3'd2,
    STS_NEW        = 3'd3,
    STS_FULL       = 3'd4,
    STS_UPDATED    = 3'd5,
    STS_IGNORED    = 3'd6,
    STS_REFRESHED  = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_EXEC
  } state_e;

  // One table row apart from its key.
  typedef struct packed {
    logic              resolved;
    logic [HOP_W-1:0]  hops;
    logic [MAC_W-1:0]  next_hop;
    logic [MAC_W-1:0]  src_mac;
    logic [IF_W-1:0]   iface;
    logic [TIME_W-1:0] stamp;
  } entry_t;

endpackage

>>> rtl/core/rct_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module rct_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/route_cache_table.sv
`timescale 1ns / 1ps
// Top level of the route cache table: command port, APB register and control.
// Depends on rct_pkg and rct_ram.
//
// The route cache table holds up to ENTRIES routes keyed by destination IPv4
// address, filled in order and never freed. A transaction is taken when
// start_i is high while busy_o is low. Every transaction yields exactly one
// result, shown for a single cycle with done_o high; the receiver cannot hold
// results off, so it must take each one in that cycle. A tick (and the unused
// command code) is answered in the next cycle and busy_o stays low, so ticks
// may be issued back to back. A lookup or update scans the key memory one slot
// per clock over the slots in use; on a match it fetches the row and executes,
// and with no match it executes once the last slot in use has been read. The
// key memory has a single read port, visited one address per cycle. The route
// fields only carry data with status hit or updated and are zero otherwise.
// The staleness register (address 0) holds seconds; it should be written only
// while the block is idle.
module route_cache_table
  import rct_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Command channel
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           cmd_i,
  input  logic [KEY_W-1:0]     dest_ip_i,
  input  logic [MAC_W-1:0]     next_hop_mac_i,
  input  logic [MAC_W-1:0]     own_mac_i,
  input  logic [IF_W-1:0]      out_interface_i,
  input  logic [HOP_W-1:0]     hop_count_i,
  // Result channel
  output logic                 done_o,
  output logic [2:0]           status_o,
  output logic [MAC_W-1:0]     route_next_hop_o,
  output logic [MAC_W-1:0]     route_src_mac_o,
  output logic [IF_W-1:0]      route_interface_o,
  output logic [HOP_W-1:0]     route_hops_o,
  // APB register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

  // Control state.
  state_e            state_q, state_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic [CW-1:0]     scan_q, scan_d;
  logic              pend_q, pend_d;
  logic [IW-1:0]     cidx_q, cidx_d;
  logic [IW-1:0]     slot_q, slot_d;
  logic              found_q, found_d;
  logic [TIME_W-1:0] clock_q, clock_d;
  logic [STALE_W-1:0] stale_q, stale_d;
  logic [TIME_W-1:0] limit_q, limit_d;
  logic              done_q, done_d;

  // Latched transaction.
  cmd_e              cmd_q, cmd_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [MAC_W-1:0]  nh_q, nh_d;
  logic [MAC_W-1:0]  src_q, src_d;
  logic [IF_W-1:0]   if_q, if_d;
  logic [HOP_W-1:0]  hop_q, hop_d;

  // Result registers.
  status_e           status_q, status_d;
  logic [MAC_W-1:0]  rnh_q, rnh_d;
  logic [MAC_W-1:0]  rsrc_q, rsrc_d;
  logic [IF_W-1:0]   rif_q, rif_d;
  logic [HOP_W-1:0]  rhop_q, rhop_d;

  // Memory ports.
  logic              key_we;
  logic [IW-1:0]     key_waddr;
  logic [KEY_W-1:0]  key_rdata;
  logic              ent_we;
  entry_t            ent_wdata;
  entry_t            ent_rdata;

  logic              accept;
  logic              cmd_valid;
  logic              more_slots;
  logic              key_match;
  logic              cfg_we;
  logic [TIME_W-1:0] age;
  entry_t            new_route;
  entry_t            fresh_entry;

  assign busy_o     = (state_q != S_IDLE);
  assign accept     = start_i && !busy_o;
  assign cmd_valid  = (cmd_i == CMD_LOOKUP) || (cmd_i == CMD_UPDATE) || (cmd_i == CMD_TICK);
  assign more_slots = (scan_q < fill_q);
  assign key_match  = pend_q && (key_rdata == key_q);

  // Key memory is scanned on its read port; the row memory is read at the
  // matched slot. All writes happen in the execute state, which is always
  // followed by the idle state, so a later scan never reads a row that is
  // still being written.
  rct_ram #(
    .WIDTH(KEY_W),
    .DEPTH(ENTRIES)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_waddr),
    .wdata_i(key_q),
    .raddr_i(scan_q[IW-1:0]),
    .rdata_o(key_rdata)
  );

  rct_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRIES)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(key_waddr),
    .wdata_i(ent_wdata),
    .raddr_i(slot_q),
    .rdata_o(ent_rdata)
  );

  // Configuration register. The millisecond limit is formed when written.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && (paddr == REG_STALENESS);
  assign stale_d = cfg_we ? pwdata[STALE_W-1:0] : stale_q;
  assign limit_d = cfg_we ? (TIME_W'(pwdata[STALE_W-1:0]) * MS_PER_SEC) : limit_q;
  assign prdata  = (paddr == REG_STALENESS) ? PDATA_W'(stale_q) : '0;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && ((cmd_i == CMD_LOOKUP) || (cmd_i == CMD_UPDATE))) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (key_match) begin
          state_d = S_FETCH;
        end else if (!more_slots && !pend_q) begin
          state_d = S_EXEC;
        end
      end
      S_FETCH: state_d = S_EXEC;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Age of the fetched row and the candidate rows to write back.
  assign age = clock_q - ent_rdata.stamp;

  always_comb begin
    new_route.resolved = 1'b1;
    new_route.hops     = hop_q;
    new_route.next_hop = nh_q;
    new_route.src_mac  = src_q;
    new_route.iface    = if_q;
    new_route.stamp    = clock_q;

    fresh_entry.resolved = 1'b0;
    fresh_entry.hops     = HOPS_UNKNOWN;
    fresh_entry.next_hop = '0;
    fresh_entry.src_mac  = '0;
    fresh_entry.iface    = '0;
    fresh_entry.stamp    = clock_q;
  end

  assign key_waddr = found_q ? slot_q : fill_q[IW-1:0];

  // Datapath and outputs per state.
  always_comb begin
    fill_d   = fill_q;
    scan_d   = scan_q;
    pend_d   = pend_q;
    cidx_d   = cidx_q;
    slot_d   = slot_q;
    found_d  = found_q;
    clock_d  = clock_q;
    cmd_d    = cmd_q;
    key_d    = key_q;
    nh_d     = nh_q;
    src_d    = src_q;
    if_d     = if_q;
    hop_d    = hop_q;
    done_d   = 1'b0;
    status_d = status_q;
    rnh_d    = rnh_q;
    rsrc_d   = rsrc_q;
    rif_d    = rif_q;
    rhop_d   = rhop_q;
    key_we   = 1'b0;
    ent_we   = 1'b0;
    ent_wdata = ent_rdata;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d   = cmd_valid ? cmd_e'(cmd_i) : CMD_TICK;
          key_d   = dest_ip_i;
          nh_d    = next_hop_mac_i;
          src_d   = own_mac_i;
          if_d    = out_interface_i;
          hop_d   = hop_count_i;
          scan_d  = '0;
          pend_d  = 1'b0;
          found_d = 1'b0;
          if ((cmd_i != CMD_LOOKUP) && (cmd_i != CMD_UPDATE)) begin
            // Tick or the unused code: answered at once.
            if (cmd_i == CMD_TICK) begin
              clock_d = clock_q + 1'b1;
            end
            done_d   = 1'b1;
            status_d = STS_IGNORED;
            rnh_d    = '0;
            rsrc_d   = '0;
            rif_d    = '0;
            rhop_d   = '0;
          end
        end
      end

      S_SCAN: begin
        if (key_match) begin
          slot_d  = cidx_q;
          found_d = 1'b1;
          pend_d  = 1'b0;
        end else if (more_slots) begin
          pend_d = 1'b1;
          cidx_d = scan_q[IW-1:0];
          scan_d = scan_q + 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end

      S_FETCH: begin
      end

      S_EXEC: begin
        done_d   = 1'b1;
        status_d = STS_IGNORED;
        rnh_d    = '0;
        rsrc_d   = '0;
        rif_d    = '0;
        rhop_d   = '0;
        if (!found_q) begin
          if (fill_q == FULL_COUNT) begin
            status_d = STS_FULL;
          end else begin
            key_we = 1'b1;
            ent_we = 1'b1;
            fill_d = fill_q + 1'b1;
            if (cmd_q == CMD_LOOKUP) begin
              ent_wdata = fresh_entry;
              status_d  = STS_NEW;
            end else begin
              ent_wdata = new_route;
              status_d  = STS_UPDATED;
              rnh_d     = nh_q;
              rsrc_d    = src_q;
              rif_d     = if_q;
              rhop_d    = hop_q;
            end
          end
        end else if (cmd_q == CMD_LOOKUP) begin
          if (!ent_rdata.resolved) begin
            status_d = STS_UNRESOLVED;
          end else if (age < limit_q) begin
            status_d = STS_HIT;
            rnh_d    = ent_rdata.next_hop;
            rsrc_d   = ent_rdata.src_mac;
            rif_d    = ent_rdata.iface;
            rhop_d   = ent_rdata.hops;
          end else begin
            ent_we             = 1'b1;
            ent_wdata.resolved = 1'b0;
            status_d           = STS_STALE;
          end
        end else begin
          if (!ent_rdata.resolved || (ent_rdata.hops > hop_q) || (age > limit_q)) begin
            ent_we    = 1'b1;
            ent_wdata = new_route;
            status_d  = STS_UPDATED;
            rnh_d     = nh_q;
            rsrc_d    = src_q;
            rif_d     = if_q;
            rhop_d    = hop_q;
          end else if (ent_rdata.hops == hop_q) begin
            ent_we          = 1'b1;
            ent_wdata.stamp = clock_q;
            status_d        = STS_REFRESHED;
          end
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      scan_q   <= '0;
      pend_q   <= 1'b0;
      cidx_q   <= '0;
      slot_q   <= '0;
      found_q  <= 1'b0;
      clock_q  <= '0;
      stale_q  <= STALENESS_RESET;
      limit_q  <= LIMIT_RESET;
      done_q   <= 1'b0;
      cmd_q    <= CMD_LOOKUP;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      scan_q   <= scan_d;
      pend_q   <= pend_d;
      cidx_q   <= cidx_d;
      slot_q   <= slot_d;
      found_q  <= found_d;
      clock_q  <= clock_d;
      stale_q  <= stale_d;
      limit_q  <= limit_d;
      done_q   <= done_d;
      cmd_q    <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    nh_q     <= nh_d;
    src_q    <= src_d;
    if_q     <= if_d;
    hop_q    <= hop_d;
    status_q <= status_d;
    rnh_q    <= rnh_d;
    rsrc_q   <= rsrc_d;
    rif_q    <= rif_d;
    rhop_q   <= rhop_d;
  end

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign route_next_hop_o  = rnh_q;
  assign route_src_mac_o   = rsrc_q;
  assign route_interface_o = rif_q;
  assign route_hops_o      = rhop_q;

endmodule

>>> rtl/core/rct_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the route cache table, bound to the top level.
// Depends on rct_pkg and route_cache_table.
module rct_checker
  import rct_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic [1:0]        cmd_i,
  input logic              done_o,
  input logic [2:0]        status_o,
  input logic [MAC_W-1:0]  route_next_hop_o,
  input logic [MAC_W-1:0]  route_src_mac_o,
  input logic [IF_W-1:0]   route_interface_o,
  input logic [HOP_W-1:0]  route_hops_o
);

  // A result is only shown once the block has gone idle again.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  // Route fields carry data only for a hit or an update.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != STS_HIT) && (status_o != STS_UPDATED)) |->
      ((route_next_hop_o == '0) && (route_src_mac_o == '0) &&
       (route_interface_o == '0) && (route_hops_o == '0)))
    else $error("route fields not zero");

  // A table transaction occupies the block and gives no result in the next cycle.
  a_table_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && ((cmd_i == CMD_LOOKUP) || (cmd_i == CMD_UPDATE))) |=>
      (busy_o && !done_o))
    else $error("table transaction did not start a scan");

  // A tick or the unused code is answered in the next cycle as ignored.
  a_tick_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (cmd_i != CMD_LOOKUP) && (cmd_i != CMD_UPDATE)) |=>
      (done_o && (status_o == STS_IGNORED) && !busy_o))
    else $error("tick not answered in one cycle");

endmodule

bind route_cache_table rct_checker u_rct_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .cmd_i            (cmd_i),
  .done_o           (done_o),
  .status_o         (status_o),
  .route_next_hop_o (route_next_hop_o),
  .route_src_mac_o  (route_src_mac_o),
  .route_interface_o(route_interface_o),
  .route_hops_o     (route_hops_o)
);
